// ----- rtl/spp_pkg.sv -----
// Spark pool package: item kinds, slot layout, controller commands and status,
// and the constant tables for spawn velocity, lifetime and colour.
// Depends on nothing; used by every module of the spark pool.
package spp_pkg;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_SPAWN = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SP_WR,
		ST_TK_RD,
		ST_TK_LOAD,
		ST_TK_MUL,
		ST_TK_ADD,
		ST_TK_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [3:0]       age;
		logic [3:0]       life;
		logic [1:0]       variant;
	} slot_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic spawn_wr;
		logic tick_start;
		logic tick_read;
		logic tick_load;
		logic tick_mul;
		logic tick_add;
		logic tick_wb;
		logic entry_read;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  spawn_fit;
		logic  spawn_last;
		logic  tick_end;
		logic  axis_last;
	} status_t;

	localparam logic signed [17:0] GAIN_Q16    = 18'sd94372;
	localparam logic signed [17:0] DECAY_Q16   = 18'sd41943;
	localparam logic signed [35:0] POS_GRAVITY = 36'sd1720;
	localparam logic signed [35:0] VEL_GRAVITY = 36'sd1106;
	localparam int                 COLOUR_LEN  = 13;

	localparam logic [2:0][31:0] VEL_AXIS = {32'd10819, 32'd9737, 32'd8655};
	localparam logic [2:0][31:0] VEL_DIAG = {32'd7650, 32'd6885, 32'd6120};
	localparam logic [2:0][31:0] VEL_FWD  = {32'd23202, 32'd20881, 32'd18561};
	localparam logic [7:0][3:0]  LIFE_TABLE =
		{4'd12, 4'd10, 4'd5, 4'd8, 4'd11, 4'd7, 4'd9, 4'd6};

	localparam logic [2:0][COLOUR_LEN-1:0][14:0] COLOUR_TABLE = {
		{15'h093F, 15'h095F, 15'h097F, 15'h097F, 15'h099F, 15'h09BF, 15'h09BF,
		 15'h09DF, 15'h09FE, 15'h0A1E, 15'h0A1E, 15'h0A3E, 15'h0A5E},
		{15'h0E9E, 15'h12BF, 15'h12DF, 15'h16DF, 15'h16FF, 15'h1B1F, 15'h1B3F,
		 15'h1B5F, 15'h1F7F, 15'h1F9F, 15'h23BF, 15'h23DF, 15'h27FF},
		{15'h335F, 15'h335F, 15'h335F, 15'h335F, 15'h375F, 15'h3B7F, 15'h437F,
		 15'h479F, 15'h4FBF, 15'h53BF, 15'h5BDF, 15'h5FFF, 15'h67FF}
	};

	// Signed step code: 2 axis, 1 diagonal, 0 none, negatives mirrored.
	function automatic logic [31:0] dir_speed(input logic [2:0] code, input logic [1:0] v);
		logic [31:0] r;
		r = 32'd0;
		case (code)
			3'd2: r = VEL_AXIS[v];
			3'd1: r = VEL_DIAG[v];
			3'd7: r = 32'd0 - VEL_DIAG[v];
			3'd6: r = 32'd0 - VEL_AXIS[v];
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0][31:0] spawn_vel(input logic [1:0] v, input logic [2:0] d);
		logic [2:0] cx;
		logic [2:0] cy;
		logic [2:0][31:0] r;
		case (d)
			3'd0: begin cx = 3'd2; cy = 3'd0; end
			3'd1: begin cx = 3'd1; cy = 3'd1; end
			3'd2: begin cx = 3'd0; cy = 3'd2; end
			3'd3: begin cx = 3'd7; cy = 3'd1; end
			3'd4: begin cx = 3'd6; cy = 3'd0; end
			3'd5: begin cx = 3'd7; cy = 3'd7; end
			3'd6: begin cx = 3'd0; cy = 3'd6; end
			default: begin cx = 3'd1; cy = 3'd7; end
		endcase
		r[0] = dir_speed(cx, v);
		r[1] = dir_speed(cy, v);
		r[2] = VEL_FWD[v];
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] s);
		logic [31:0] r;
		if (s > 36'sh0_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -36'sh0_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/spp_ctrl.sv -----
// Spark pool controller: the sequencing state machine.
// Depends on spp_pkg; drives spp_dpath through cmd_t and reads status_t.
module spp_ctrl import spp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_free,
	input  status_t status,
	output logic    in_ready,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_nx = ST_DECODE;
			ST_DECODE: begin
				unique case (status.kind)
					KIND_SPAWN: state_nx = status.spawn_fit ? ST_SP_WR : ST_DONE;
					KIND_TICK:  state_nx = ST_TK_RD;
					default:    state_nx = ST_DONE;
				endcase
			end
			ST_SP_WR:   if (status.spawn_last) state_nx = ST_DONE;
			ST_TK_RD:   state_nx = status.tick_end ? ST_DONE : ST_TK_LOAD;
			ST_TK_LOAD: state_nx = ST_TK_MUL;
			ST_TK_MUL:  state_nx = ST_TK_ADD;
			ST_TK_ADD:  state_nx = status.axis_last ? ST_TK_WB : ST_TK_MUL;
			ST_TK_WB:   state_nx = ST_TK_RD;
			ST_DONE:    if (out_free) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_DECODE: begin
				cmd.clear      = (status.kind == KIND_CLEAR);
				cmd.tick_start = (status.kind == KIND_TICK);
				cmd.entry_read = (status.kind == KIND_READ);
			end
			ST_SP_WR:   cmd.spawn_wr = 1'b1;
			ST_TK_RD:   cmd.tick_read = !status.tick_end;
			ST_TK_LOAD: cmd.tick_load = 1'b1;
			ST_TK_MUL:  cmd.tick_mul = 1'b1;
			ST_TK_ADD:  cmd.tick_add = 1'b1;
			ST_TK_WB:   cmd.tick_wb = 1'b1;
			ST_DONE:    cmd.result_load = out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

// ----- rtl/spp_dpath.sv -----
// Spark pool datapath: slot memory, counters, fixed-point integrator and
// result assembly. Depends on spp_pkg; commanded by spp_ctrl.
module spp_dpath import spp_pkg::*; #(
	parameter int POOL_SLOTS   = 64,
	parameter int COLOUR_STEPS = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic [1:0]    in_kind,
	input  logic [103:0]  in_data,
	output status_t       status,
	output logic [127:0]  result
);

	localparam int IW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CW  = $clog2(POOL_SLOTS + 1);
	localparam int CAP = ((COLOUR_STEPS < COLOUR_LEN) ? COLOUR_STEPS : COLOUR_LEN) - 1;

	slot_t            mem [POOL_SLOTS];
	slot_t            rdata_q;
	slot_t            work_q;
	logic             we;
	logic [IW-1:0]    waddr;
	slot_t            wdata;
	logic             re;
	logic [IW-1:0]    raddr;

	kind_t            kind_q;
	logic [2:0][31:0] spos_q;
	logic [5:0]       idx_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    i_q;
	logic [2:0]       serial_q;
	logic [1:0]       var_q;
	logic [1:0]       axis_q;
	logic             move_q;
	logic             acc_q;
	logic signed [49:0] prod_g_q;
	logic signed [49:0] prod_d_q;

	logic signed [31:0] vel_a;
	logic signed [49:0] rg_full;
	logic signed [49:0] rd_full;
	logic signed [35:0] pos_sum;
	logic signed [35:0] vel_sum;
	logic [3:0]         age_nx;
	logic               dies;
	logic [CW-1:0]      last;
	logic [2:0]         dir;
	logic               entry_valid;
	logic [3:0]         cidx;

	assign last  = count_q - CW'(1);
	assign vel_a = work_q.vel[axis_q];
	assign rg_full = prod_g_q + 50'sd32768;
	assign rd_full = prod_d_q + 50'sd32768;
	assign pos_sum = 36'($signed(work_q.pos[axis_q])) + 36'($signed(rg_full[49:16]))
		- ((axis_q == 2'd1) ? POS_GRAVITY : 36'sd0);
	assign vel_sum = 36'($signed(rd_full[49:16]))
		- ((axis_q == 2'd1) ? VEL_GRAVITY : 36'sd0);
	assign age_nx = work_q.age + 4'd1;
	assign dies   = (age_nx >= work_q.life);
	assign dir    = serial_q + {var_q, 1'b0} + {2'b00, (var_q == 2'd2)};

	always_comb begin
		we    = 1'b0;
		waddr = i_q[IW-1:0];
		wdata = work_q;
		if (cmd.spawn_wr) begin
			we            = 1'b1;
			waddr         = count_q[IW-1:0];
			wdata.pos     = spos_q;
			wdata.vel     = spawn_vel(var_q, dir);
			wdata.age     = 4'd0;
			wdata.life    = LIFE_TABLE[serial_q];
			wdata.variant = var_q;
		end else if (cmd.tick_wb && !dies) begin
			we        = 1'b1;
			wdata.age = age_nx;
		end
	end

	always_comb begin
		re    = cmd.tick_read || (cmd.entry_read && ({{CW{1'b0}}, idx_q} < {6'd0, count_q}));
		raddr = cmd.entry_read ? IW'(idx_q) :
			(move_q ? count_q[IW-1:0] : i_q[IW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q    <= kind_t'(in_kind);
			spos_q[0] <= in_data[31:0];
			spos_q[1] <= in_data[63:32];
			spos_q[2] <= in_data[95:64];
			idx_q     <= in_data[101:96];
		end
		if (cmd.tick_load) work_q <= rdata_q;
		if (cmd.tick_mul) begin
			prod_g_q <= vel_a * GAIN_Q16;
			prod_d_q <= vel_a * DECAY_Q16;
		end
		if (cmd.tick_add) begin
			work_q.pos[axis_q] <= sat32(pos_sum);
			work_q.vel[axis_q] <= sat32(vel_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			serial_q <= '0;
			i_q      <= '0;
			var_q    <= '0;
			axis_q   <= '0;
			move_q   <= 1'b0;
			acc_q    <= 1'b0;
		end else begin
			if (cmd.take) begin
				acc_q  <= 1'b0;
				var_q  <= '0;
				axis_q <= '0;
			end
			if (cmd.clear) begin
				count_q  <= '0;
				serial_q <= '0;
				i_q      <= '0;
			end
			if (cmd.spawn_wr) begin
				count_q <= count_q + CW'(1);
				var_q   <= var_q + 2'd1;
				if (var_q == 2'd2) begin
					serial_q <= serial_q + 3'd1;
					acc_q    <= 1'b1;
				end
			end
			if (cmd.tick_start) begin
				i_q    <= '0;
				move_q <= 1'b0;
			end
			if (cmd.tick_add) axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
			if (cmd.tick_wb) begin
				if (dies) begin
					count_q <= last;
					move_q  <= (i_q != last);
				end else begin
					i_q    <= i_q + CW'(1);
					move_q <= 1'b0;
				end
			end
		end
	end

	assign status.kind       = kind_q;
	assign status.spawn_fit  = (32'(count_q) <= 32'(POOL_SLOTS - 3));
	assign status.spawn_last = (var_q == 2'd2);
	assign status.tick_end   = (i_q >= count_q);
	assign status.axis_last  = (axis_q == 2'd2);

	assign entry_valid = (kind_q == KIND_READ) && ({{CW{1'b0}}, idx_q} < {6'd0, count_q});
	assign cidx = (rdata_q.age > 4'(CAP)) ? 4'(CAP) : rdata_q.age;

	always_comb begin
		result          = '0;
		result[0]       = acc_q;
		result[7:1]     = 7'(count_q);
		result[8]       = entry_valid;
		if (entry_valid) begin
			result[40:9]    = rdata_q.pos[0];
			result[72:41]   = rdata_q.pos[1];
			result[104:73]  = rdata_q.pos[2];
			result[106:105] = rdata_q.variant;
			result[110:107] = rdata_q.age;
			result[125:111] = COLOUR_TABLE[(rdata_q.variant > 2'd2) ? 2'd0 : rdata_q.variant][cidx];
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= POOL_SLOTS) else $error("live count beyond pool size");
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= count_q) else $error("tick walker passed the live count");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0) && (serial_q == 3'd0)) else $error("clear left state");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take) |=> $stable(serial_q)) else $error("serial moved on item take");
`endif

endmodule

// ----- rtl/spark_particle_pool_core.sv -----
// Spark pool core: a packed pool of sparks driven by clear, spawn, tick and read items.
// A spawn writes three sparks or is dropped when under three slots are free; a tick takes each
// live spark in turn (one memory read, a load, then a multiply and an add for each of the three axes,
// and a write-back).
// One item is worked at a time; the next is taken once the result sits in the output register.
// Reset (arst_n low, asynchronous) empties the pool and zeroes the burst serial.
module spark_particle_pool_core import spp_pkg::*; #(
	parameter int POOL_SLOTS   = 64,
	parameter int COLOUR_STEPS = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // spawn_x, spawn_y, spawn_z, entry_index, zero fill
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // accepted, live_total, entry_valid, out_x, out_y,
	                               // out_z, out_variant, out_age, out_colour, zero fill
);

	cmd_t         cmd;
	status_t      status;
	logic [127:0] result;
	logic         m_tvalid_q;
	logic [127:0] m_tdata_q;
	logic         out_free;

	// The output register frees when it is empty or its item is being taken.
	assign out_free = !m_tvalid_q || m_tready;

	spp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.status   (status),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	spp_dpath #(
		.POOL_SLOTS   (POOL_SLOTS),
		.COLOUR_STEPS (COLOUR_STEPS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_kind (s_tuser),
		.in_data (s_tdata),
		.status  (status),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.result_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) m_tdata_q <= result;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
